@@ hw/rtl/itfr_pkg.sv @@
`default_nettype none

package itfr_pkg;

   localparam int unsigned DefBufferDepth = 256;
   localparam logic [15:0] IdleLimitReset = 16'd840;

   typedef enum logic [1:0] {
      OpByte = 2'd0,
      OpTick = 2'd1,
      OpRead = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RespNone  = 2'd0,
      RespOk    = 2'd1,
      RespError = 2'd2
   } resp_type;

   localparam logic KindFrame = 1'b0;
   localparam logic KindRead  = 1'b1;

   // Byte 0 of each pattern sits in the lowest lane.
   localparam int unsigned OkLen  = 6;
   localparam int unsigned ErrLen = 9;
   localparam logic [8:0][7:0] OkPat =
      {24'h000000, 8'h0A, 8'h0D, "K", "O", 8'h0A, 8'h0D};
   localparam logic [8:0][7:0] ErrPat =
      {8'h0A, 8'h0D, "R", "O", "R", "R", "E", 8'h0A, 8'h0D};

   typedef struct packed {
      logic       push;   // byte lands inside the frame text window
      logic       clear;  // frame closed, restart the search
      logic [7:0] data;
   } match_ctl_type;

   // Longest pattern prefix that ends the matched text after one more byte.
   function automatic logic [3:0] pat_next(input logic [3:0] state,
                                           input logic [7:0] ch,
                                           input logic [8:0][7:0] pat,
                                           input int unsigned plen);
      logic [3:0] best;
      logic       hit;
      best = '0;
      for (int k = 1; k <= 9; k++) begin
         hit = (k <= int'(state) + 1) && (k <= int'(plen)) && (pat[k-1] == ch);
         for (int j = 0; j < 8; j++) begin
            if (hit && (j < k - 1)) begin
               if (pat[j] != pat[int'(state) - k + 1 + j]) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit) begin
            best = 4'(k);
         end
      end
      return best;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/idle_timeout_frame_receiver_core.sv @@
`default_nettype none

// Idle-timeout frame receiver.
// req channel: one beat per command. tuser selects the command (received byte,
// timer tick, buffer read); tdata carries the byte and the read position.
// Bytes are stored in an on-chip buffer at a running count that saturates at
// the last slot. Each byte restarts the idle timer. Once the running timer
// has seen csr idle_limit ticks, the frame closes and one rsp beat reports
// the frame length and whether "\r\nOK\r\n" or "\r\nERROR\r\n" appeared.
// A read command returns one rsp beat with the stored byte.
// A result passes through the read stage and then the output register.
// Throughput: one request beat per cycle unless both result stages are held;
// the buffer has one write and one registered read port; bytes and ticks produce no rsp beat.
// Stall: a result waits in the output register; a second result waits in the
// read stage; req_tready drops only while both are held.
// Reset: count, timer and matchers clear, idle_limit returns to 840; the
// buffer contents are left as they are and need no clearing pass.
// csr: csr_wen writes idle_limit; the user writes only while idle, unchecked.
module idle_timeout_frame_receiver_core #(
   parameter int unsigned BUFFER_DEPTH = itfr_pkg::DefBufferDepth
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [7:0] rx_data, [15:8] read_index
   input  wire  [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] frame_length, [9:8] response_code,
                                    // [17:10] read_data, [23:18] zero
   output logic [0:0]  rsp_tuser,   // [0] result_kind
   input  wire         csr_wen,
   input  wire  [15:0] csr_wdata    // idle_limit
);
   import itfr_pkg::*;

   localparam int unsigned AW = $clog2(BUFFER_DEPTH);
   localparam logic [AW-1:0] LastSlot = AW'(BUFFER_DEPTH - 1);

   // Control state
   logic [15:0]   idle_limit_ff, idle_limit_in;
   logic [AW-1:0] count_ff, count_in;
   logic          running_ff, running_in;
   logic [15:0]   idle_ff, idle_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload held in the read stage and the output register
   logic          s1_kind_ff;
   logic [7:0]    s1_len_ff;
   resp_type      s1_code_ff;
   logic          s1_inrange_ff;
   logic [7:0]    rd_data_ff;
   logic          rsp_kind_ff;
   logic [7:0]    rsp_len_ff;
   resp_type      rsp_code_ff;
   logic [7:0]    rsp_data_ff;

   logic [7:0]    mem [BUFFER_DEPTH];

   op_type        op;
   logic          accept;
   logic          is_byte, is_tick, is_read;
   logic [15:0]   tick_next;
   logic          frame_end;
   logic          has_result;
   logic          s1_move;
   logic          in_range;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [7:0]    len_sat;
   match_ctl_type mctl;
   resp_type      code_now;

   assign op     = op_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      is_byte = 1'b0;
      is_tick = 1'b0;
      is_read = 1'b0;
      unique case (op)
         OpByte:  is_byte = 1'b1;
         OpTick:  is_tick = 1'b1;
         OpRead:  is_read = 1'b1;
         default: ;  // unused code: drop
      endcase
   end

   // Saturating idle tick count and frame-end decision
   assign tick_next  = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign frame_end  = accept && is_tick && running_ff && (tick_next >= idle_limit_ff);
   assign has_result = frame_end || (accept && is_read);

   assign in_range = 32'(req_tdata[15:8]) < 32'(BUFFER_DEPTH);
   assign rd_addr  = AW'(32'(req_tdata[15:8]));
   assign len_sat  = (32'(count_ff) > 32'd255) ? 8'hFF : 8'(32'(count_ff));

   // Store bytes at the count; close the frame with a zero at the count
   assign mem_we    = accept && (is_byte || frame_end);
   assign mem_wdata = is_byte ? req_tdata[7:0] : 8'h00;

   // Only slots below the last one can be part of the frame text
   assign mctl.push  = accept && is_byte && (count_ff != LastSlot);
   assign mctl.clear = frame_end;
   assign mctl.data  = req_tdata[7:0];

   itfr_match u_match (
      .clock         (clock),
      .reset         (reset),
      .ctl           (mctl),
      .response_code (code_now)
   );

   // Read stage drains into the output register whenever that is free
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;

   always_comb begin
      idle_limit_in = csr_wen ? csr_wdata : idle_limit_ff;
      count_in      = count_ff;
      running_in    = running_ff;
      idle_in       = idle_ff;
      if (accept && is_byte) begin
         if (count_ff != LastSlot) begin
            count_in = count_ff + AW'(1);
         end
         running_in = 1'b1;
         idle_in    = '0;
      end else if (frame_end) begin
         count_in   = '0;
         running_in = 1'b0;
         idle_in    = '0;
      end else if (accept && is_tick && running_ff) begin
         idle_in = tick_next;
      end

      if (has_result) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IdleLimitReset;
         count_ff      <= '0;
         running_ff    <= 1'b0;
         idle_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         idle_limit_ff <= idle_limit_in;
         count_ff      <= count_in;
         running_ff    <= running_in;
         idle_ff       <= idle_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Frame buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff] <= mem_wdata;
      end
      if (accept && is_read && in_range) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Capture result fields alongside the buffer read
   always_ff @(posedge clock) begin
      if (has_result) begin
         s1_kind_ff    <= is_read ? KindRead : KindFrame;
         s1_len_ff     <= is_read ? 8'h00 : len_sat;
         s1_code_ff    <= is_read ? RespNone : code_now;
         s1_inrange_ff <= in_range;
      end
      if (s1_move) begin
         rsp_kind_ff <= s1_kind_ff;
         rsp_len_ff  <= s1_len_ff;
         rsp_code_ff <= s1_code_ff;
         rsp_data_ff <= (s1_kind_ff == KindRead && s1_inrange_ff) ? rd_data_ff : 8'h00;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_data_ff, rsp_code_ff, rsp_len_ff};
   assign rsp_tuser  = rsp_kind_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LastSlot)
      else $error("byte count passed the last buffer slot");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (count_ff == '0) && !running_ff)
      else $error("frame end did not clear count and timer");

   a_stopped_timer_idle: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (idle_ff == '0))
      else $error("idle ticks nonzero while timer stopped");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while both result stages are held");

endmodule

`default_nettype wire

@@ hw/rtl/itfr_match.sv @@
`default_nettype none

module itfr_match (
   input  wire                     clock,
   input  wire                     reset,
   input  itfr_pkg::match_ctl_type ctl,
   output itfr_pkg::resp_type      response_code
);
   import itfr_pkg::*;

   logic [2:0] ok_prog_ff,  ok_prog_in;
   logic [3:0] err_prog_ff, err_prog_in;
   logic       ok_found_ff, ok_found_in;
   logic       err_found_ff, err_found_in;
   logic       zero_seen_ff, zero_seen_in;
   logic [3:0] ok_step;
   logic [3:0] err_step;

   assign ok_step  = pat_next({1'b0, ok_prog_ff}, ctl.data, OkPat, OkLen);
   assign err_step = pat_next(err_prog_ff, ctl.data, ErrPat, ErrLen);

   always_comb begin
      ok_prog_in   = ok_prog_ff;
      err_prog_in  = err_prog_ff;
      ok_found_in  = ok_found_ff;
      err_found_in = err_found_ff;
      zero_seen_in = zero_seen_ff;
      if (ctl.clear) begin
         ok_prog_in   = '0;
         err_prog_in  = '0;
         ok_found_in  = 1'b0;
         err_found_in = 1'b0;
         zero_seen_in = 1'b0;
      end else if (ctl.push && !zero_seen_ff) begin
         // a zero byte terminates the text: freeze the search
         if (ctl.data == 8'h00) begin
            zero_seen_in = 1'b0 | 1'b1;
         end else begin
            if (ok_step == 4'(OkLen)) begin
               ok_found_in = 1'b1;
               ok_prog_in  = '0;
            end else begin
               ok_prog_in = ok_step[2:0];
            end
            if (err_step == 4'(ErrLen)) begin
               err_found_in = 1'b1;
               err_prog_in  = '0;
            end else begin
               err_prog_in = err_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_prog_ff   <= '0;
         err_prog_ff  <= '0;
         ok_found_ff  <= 1'b0;
         err_found_ff <= 1'b0;
         zero_seen_ff <= 1'b0;
      end else begin
         ok_prog_ff   <= ok_prog_in;
         err_prog_ff  <= err_prog_in;
         ok_found_ff  <= ok_found_in;
         err_found_ff <= err_found_in;
         zero_seen_ff <= zero_seen_in;
      end
   end

   always_comb begin
      if (ok_found_ff) begin
         response_code = RespOk;
      end else if (err_found_ff) begin
         response_code = RespError;
      end else begin
         response_code = RespNone;
      end
   end

endmodule

`default_nettype wire

@@ dv/frame_receiver_checker.sv @@
module frame_receiver_checker #(
   parameter int unsigned DEPTH = itfr_pkg::DefBufferDepth
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [15:0] req_tdata,   // [7:0] rx_data, [15:8] read_index
   input  wire  [1:0]  req_tuser,   // [1:0] opcode
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [23:0] rsp_tdata,   // [7:0] frame_length, [9:8] response_code,
                                    // [17:10] read_data
   input  wire  [0:0]  rsp_tuser,   // [0] result_kind
   input  wire         csr_wen,
   input  wire  [15:0] csr_wdata,   // idle_limit
   output int unsigned mismatches,
   output int unsigned waiting
);
   import itfr_pkg::*;

   typedef struct packed {
      logic       kind;
      logic [7:0] length;
      logic [1:0] code;
      logic [7:0] rdata;
   } rsp_fields_type;

   logic [7:0]  frame_mem [DEPTH];
   int unsigned fill;
   bit          timer_on;
   int unsigned idle_ticks;
   logic [15:0] idle_limit;
   rsp_fields_type due_rsp [$];

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t rsp beat %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Plain substring search over the first tlen stored bytes.
   function automatic bit text_has(int unsigned tlen, logic [8:0][7:0] pat,
                                   int unsigned plen);
      bit hit;
      for (int unsigned s = 0; s + plen <= tlen; s++) begin
         hit = 1'b1;
         for (int unsigned k = 0; k < plen; k++) begin
            if (frame_mem[s + k] !== pat[k]) hit = 1'b0;
         end
         if (hit) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic close_frame();
      int unsigned tlen;
      rsp_fields_type r;
      frame_mem[fill] = 8'h00;
      tlen = 0;
      while (tlen < fill && frame_mem[tlen] != 8'h00) tlen++;
      r.kind   = KindFrame;
      r.length = (fill > 255) ? 8'd255 : 8'(fill);
      if (text_has(tlen, OkPat, OkLen)) r.code = RespOk;
      else if (text_has(tlen, ErrPat, ErrLen)) r.code = RespError;
      else r.code = RespNone;
      r.rdata  = 8'h00;
      due_rsp.push_back(r);
      fill       = 0;
      timer_on   = 1'b0;
      idle_ticks = 0;
   endtask

   task automatic take_command(logic [1:0] op, logic [7:0] data, logic [7:0] idx);
      rsp_fields_type r;
      case (op)
         OpByte: begin
            frame_mem[fill] = data;
            if (fill < DEPTH - 1) fill++;
            idle_ticks = 0;
            timer_on   = 1'b1;
         end
         OpTick: if (timer_on) begin
            if (idle_ticks < 16'hFFFF) idle_ticks++;
            if (idle_ticks >= idle_limit) close_frame();
         end
         OpRead: begin
            r.kind   = KindRead;
            r.length = 8'h00;
            r.code   = RespNone;
            r.rdata  = (idx < DEPTH) ? frame_mem[idx] : 8'h00;
            due_rsp.push_back(r);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_fields_type want;
      if (reset) begin
         fill       = 0;
         timer_on   = 1'b0;
         idle_ticks = 0;
         idle_limit = IdleLimitReset;
         mismatches = 0;
         due_rsp.delete();
      end else begin
         if (csr_wen) idle_limit = csr_wdata;
         if (req_tvalid && req_tready) begin
            take_command(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_rsp.size() == 0) begin
               report_mismatch("with nothing due, result_kind", rsp_tuser[0], 0);
            end else begin
               want = due_rsp.pop_front();
               if (rsp_tuser[0] !== want.kind)
                  report_mismatch("result_kind", rsp_tuser[0], want.kind);
               if (rsp_tdata[7:0] !== want.length)
                  report_mismatch("frame_length", rsp_tdata[7:0], want.length);
               if (rsp_tdata[9:8] !== want.code)
                  report_mismatch("response_code", rsp_tdata[9:8], want.code);
               if (rsp_tdata[17:10] !== want.rdata)
                  report_mismatch("read_data", rsp_tdata[17:10], want.rdata);
            end
         end
      end
      waiting <= due_rsp.size();
   end

endmodule

@@ dv/idle_timeout_frame_receiver_core_tb.sv @@
module idle_timeout_frame_receiver_core_tb;
   import itfr_pkg::*;

   // Opcode the block has no use for; it must swallow the beat silently.
   localparam logic [1:0] OpSpare = 2'd3;
   localparam logic [7:0] CharCr  = 8'h0D;
   localparam logic [7:0] CharLf  = 8'h0A;
   localparam int unsigned RandomItems = 400;

   typedef enum int {
      ReplyNone,
      ReplyOk,
      ReplyError,
      ReplyBoth,
      ReplyCutOk,
      ReplyCutError
   } reply_kind_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] rx_data, [15:8] read_index
   logic [1:0]  req_tuser  = '0;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [7:0] frame_length, [9:8] response_code,
                                   // [17:10] read_data
   logic [0:0]  rsp_tuser;         // [0] result_kind
   logic        csr_wen    = 1'b0;
   logic [15:0] csr_wdata  = '0;   // idle_limit

   int unsigned mismatches;
   int unsigned open_results;

   // Idling knobs in percent, and a one-shot request for a long receiver hold-off.
   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_ask  = 0;

   // Light mirror of count and timer. It only steers stimulus: it says when a
   // frame has closed and which buffer slots hold defined data (always a
   // prefix starting at slot 0), so reads never touch unwritten slots.
   int unsigned mir_count   = 0;
   int unsigned mir_ticks   = 0;
   int unsigned mir_limit   = IdleLimitReset;
   bit          mir_running = 1'b0;
   int unsigned slots_known = 0;
   int unsigned items_done  = 0;
   int unsigned frame_no    = 0;
   logic [7:0]  frame_bytes [$];

   idle_timeout_frame_receiver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   frame_receiver_checker rx_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .waiting    (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop; far beyond the slowest legal run (one frame closed at the
   // default limit plus under two thousand beats under heavy stalls).
   initial begin
      #6_000_000;
      $display("idle_timeout_frame_receiver_core: mismatch");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off counted here when the
   // stimulus asks for one.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Advance the mirror for one accepted beat.
   function automatic void track(logic [1:0] op);
      case (op)
         OpByte: begin
            if (mir_count + 1 > slots_known) slots_known = mir_count + 1;
            if (mir_count < DefBufferDepth - 1) mir_count++;
            mir_running = 1'b1;
            mir_ticks   = 0;
            items_done++;
         end
         OpTick: if (mir_running) begin
            items_done++;
            if (mir_ticks < 16'hFFFF) mir_ticks++;
            if (mir_ticks >= mir_limit) begin
               // closing zeroes the slot at the count, so it becomes defined too
               if (mir_count + 1 > slots_known) slots_known = mir_count + 1;
               mir_count   = 0;
               mir_running = 1'b0;
               mir_ticks   = 0;
            end
         end
         OpRead: items_done++;
         default: ;
      endcase
   endfunction

   // Offer one beat after an optional random gap; hold it until accepted.
   // Leave tvalid high afterwards so back-to-back beats never toggle it.
   task automatic issue(logic [1:0] op, logic [7:0] data, logic [7:0] idx);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {idx, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track(op);
   endtask

   function automatic logic [7:0] pick_slot();
      case ($urandom_range(9))
         0:       return 8'd0;
         1, 2:    return 8'(slots_known - 1);
         default: return 8'($urandom_range(slots_known - 1, 0));
      endcase
   endfunction

   task automatic send_read();
      if (slots_known != 0) issue(OpRead, 8'($urandom), pick_slot());
   endtask

   // Noise: an ignored opcode, or a tick that cannot yet close the frame.
   task automatic stray();
      if (mir_running && mir_ticks + 1 < mir_limit && $urandom_range(1) == 1) begin
         issue(OpTick, 8'($urandom), 8'($urandom));
      end else begin
         issue(OpSpare, 8'($urandom), 8'($urandom));
      end
   endtask

   // Tick until the frame closes; sprinkle reads in only when asked.
   task automatic tick_out(bit with_reads);
      while (mir_running) begin
         if (with_reads && $urandom_range(11) == 0) send_read();
         issue(OpTick, 8'($urandom), 8'($urandom));
      end
   endtask

   // Lean toward the pattern alphabet so near-misses are common.
   function automatic logic [7:0] draw_char();
      case ($urandom_range(5))
         0:       return CharCr;
         1:       return CharLf;
         2:       return ($urandom_range(1) == 1) ? "O" : "K";
         3:       return ($urandom_range(1) == 1) ? "E" : "R";
         default: return 8'($urandom);
      endcase
   endfunction

   // Append CR LF text CR LF; a cut line drops the final LF.
   function automatic void append_line(string s, bit cut);
      frame_bytes.push_back(CharCr);
      frame_bytes.push_back(CharLf);
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
      frame_bytes.push_back(CharCr);
      if (!cut) frame_bytes.push_back(CharLf);
   endfunction

   function automatic void append_reply(reply_kind_type r);
      case (r)
         ReplyOk:       append_line("OK", 1'b0);
         ReplyError:    append_line("ERROR", 1'b0);
         ReplyBoth: begin
            append_line("ERROR", 1'b0);
            append_line("OK", 1'b0);
         end
         ReplyCutOk:    append_line("OK", 1'b1);
         ReplyCutError: append_line("ERROR", 1'b1);
         default: ;
      endcase
   endfunction

   task automatic send_bytes(bit mixed);
      foreach (frame_bytes[i]) begin
         if (mixed && $urandom_range(7) == 0) send_read();
         else if (mixed && $urandom_range(19) == 0) stray();
         issue(OpByte, frame_bytes[i], 8'($urandom));
      end
   endtask

   // One frame: random text around an optional reply, sometimes a zero byte,
   // once with a long body that can saturate the count. Most frames close by
   // ticks; a few stay open and run into the next one.
   task automatic random_frame();
      int unsigned body_len;
      int unsigned cut;
      reply_kind_type reply;
      frame_no++;
      frame_bytes.delete();
      if (frame_no == 5) body_len = $urandom_range(300, 250);
      else body_len = $urandom_range(10, 0);
      reply = reply_kind_type'($urandom_range(ReplyCutError));
      cut   = $urandom_range(body_len);
      for (int i = 0; i < cut; i++) frame_bytes.push_back(draw_char());
      append_reply(reply);
      for (int i = cut; i < body_len; i++) frame_bytes.push_back(draw_char());
      if ($urandom_range(9) == 0) frame_bytes.insert($urandom_range(frame_bytes.size()), 8'h00);
      if (frame_bytes.size() == 0) frame_bytes.push_back(draw_char());
      send_bytes(1'b1);
      if ($urandom_range(9) != 0) tick_out(1'b1);
   endtask

   // Drop tvalid and wait until every due result has come back, then give the
   // pipeline time to drain (bytes and ticks leave no result beat).
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(logic [15:0] value);
      settle();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      mir_limit = value;
   endtask

   task automatic set_idling(int unsigned gap, int unsigned stall);
      gap_pct   = gap;
      stall_pct = stall;
   endtask

   initial begin
      int unsigned base;
      logic [15:0] phase_limit [8];
      phase_limit = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd5, 16'd1, 16'd4, 16'd2};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(0, 0);

      // Out of reset, default limit: a tick while stopped and a spare opcode
      // must do nothing; then a frame whose text ends at an early zero byte,
      // so the OK line after it must not count.
      issue(OpTick, 8'hFF, 8'hFF);
      issue(OpSpare, 8'h00, 8'h00);
      frame_bytes.delete();
      frame_bytes.push_back(8'hFF);
      frame_bytes.push_back(8'h00);
      append_reply(ReplyOk);
      send_bytes(1'b0);
      issue(OpRead, 8'hFF, 8'd0);
      issue(OpRead, 8'h00, 8'd1);
      tick_out(1'b0);

      // Small limit: a clean ERROR reply, then read back its last byte.
      set_limit(16'd2);
      frame_bytes.delete();
      append_reply(ReplyError);
      send_bytes(1'b0);
      tick_out(1'b0);
      issue(OpRead, 8'h5A, 8'd8);

      // Limit zero: the first tick of a running timer closes the frame.
      set_limit(16'd0);
      issue(OpByte, 8'h80, 8'h7F);
      issue(OpTick, 8'h01, 8'h80);

      // One tick short must keep the frame open, which the read placed
      // before the last tick shows by arriving first.
      set_limit(16'd12);
      issue(OpByte, 8'h41, 8'h00);
      repeat (11) issue(OpTick, 8'($urandom), 8'($urandom));
      issue(OpRead, 8'h00, 8'd0);
      issue(OpTick, 8'($urandom), 8'($urandom));

      // Random frames over several limits and idling mixes.
      base = items_done;
      for (int ph = 0; ph < 8; ph++) begin
         set_limit(phase_limit[ph]);
         case (ph % 4)
            0: set_idling(0, 0);
            1: set_idling(47, 0);
            2: set_idling(0, 47);
            default: set_idling(9, 9);
         endcase
         do begin
            random_frame();
            // pause the sender until every due result is back
            if (ph == 5) settle();
         end while (items_done < base + (ph + 1) * RandomItems / 8);
         if (ph == 2) begin
            // hold the result side off while reads keep coming: the block
            // must fill up and drop req_tready
            hold_ask = 300;
            repeat (24) send_read();
         end
      end

      settle();
      if (mismatches == 0 && open_results == 0) begin
         $display("idle_timeout_frame_receiver_core: match");
      end else begin
         $display("idle_timeout_frame_receiver_core: mismatch");
      end
      $finish;
   end

endmodule
